[src/matrix_trace_repeat_counter_unit_macros.svh]
// Assertion helpers used by the checker file mtrc_checker.sv.
`ifndef MATRIX_TRACE_REPEAT_COUNTER_UNIT_MACROS_SVH
`define MATRIX_TRACE_REPEAT_COUNTER_UNIT_MACROS_SVH

// Checked on every rising edge, held off while reset is asserted.
`define MTRC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MTRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/mtrc_pkg.sv]
package mtrc_pkg;

	// Largest supported side length and the position width it needs
	localparam int SideLimit   = 128;
	localparam int PosW        = 7;
	localparam int SizeW       = 8;
	localparam int DefaultMaxN = 128;

	// Field widths
	localparam int ValueW = 8;
	localparam int TraceW = 15;
	localparam int CountW = 8;
	localparam int MDataW = 32;

endpackage

[src/mtrc_col_ram.sv]
// Per-column seen-value bitmaps: one write port, one registered read port.
module mtrc_col_ram #(
	parameter int DataW = mtrc_pkg::DefaultMaxN
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [mtrc_pkg::PosW-1:0] waddr,
	input  logic [DataW-1:0]          wdata,
	input  logic                      re,
	input  logic [mtrc_pkg::PosW-1:0] raddr,
	output logic [DataW-1:0]          rdata
);
	import mtrc_pkg::*;

	logic [DataW-1:0] mem [SideLimit];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/matrix_trace_repeat_counter_unit.sv]
// Channel   Dir  Width  Contents (low bit first)
// cfg       in   8      matrix_size (write enable cfg_we)
// s_axis    in   8+1    tdata: value; tuser: first_item
// m_axis    out  32+1   tdata: trace_sum, rows_with_repeat, cols_with_repeat; tuser: value_error
//
// One element per cycle: two stages, s0 issues the column bitmap read, s1 tests,
// sets and writes the bitmap back (same-column hazards are forwarded).
// A result is written to the output register when the last element retires from s1.
// Input stalls only when a final element meets an output register not yet taken.
// arst_n clears positions, totals, repeat flags and size (128); bitmaps need no clear.
module matrix_trace_repeat_counter_unit #(
	parameter int MAX_N = mtrc_pkg::DefaultMaxN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mtrc_pkg::SizeW-1:0]    cfg_wdata,   // matrix_size
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mtrc_pkg::ValueW-1:0]   s_tdata,     // value
	input  logic                          s_tuser,     // first_item
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mtrc_pkg::MDataW-1:0]   m_tdata,     // trace_sum, rows_with_repeat, cols_with_repeat
	output logic                          m_tuser      // value_error
);
	import mtrc_pkg::*;

	localparam int IdxW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	typedef struct packed {
		logic [ValueW-1:0] value;
		logic [PosW-1:0]   col;
		logic              restart;
		logic              row_first;
		logic              col_first;
		logic              diag;
		logic              last;
	} stage_t;

	// Configuration and position state
	logic [SizeW-1:0] size_q;
	logic [SizeW-1:0] side_n;
	logic [PosW-1:0]  row_q, col_q;

	// Stage 1 state
	logic             valid_s1;
	stage_t           st_s1;
	logic             fwd_s1;
	logic [MAX_N-1:0] fwd_data_s1;

	// Matrix accumulation state
	logic [MAX_N-1:0]     row_seen_q;
	logic                 row_has_q;
	logic [SideLimit-1:0] col_has_q;
	logic [TraceW-1:0]    trace_q;
	logic [CountW-1:0]    row_tot_q, col_tot_q;
	logic                 err_q;

	// Output register
	logic              out_valid_q;
	logic [TraceW-1:0] out_trace_q;
	logic [CountW-1:0] out_rows_q, out_cols_q;
	logic              out_err_q;

	// Clamp side length to 1..SideLimit
	always_comb begin
		priority if (size_q == '0) begin
			side_n = SizeW'(1);
		end else if (size_q > SizeW'(SideLimit)) begin
			side_n = SizeW'(SideLimit);
		end else begin
			side_n = size_q;
		end
	end

	// ---------------- stage 0: position tracking, bitmap read ----------------
	logic             accept, retire;
	logic [PosW-1:0]  r0, c0;
	logic [PosW:0]    r_inc, c_inc;
	logic             col_wrap, mat_done;
	stage_t           st0;

	assign accept   = s_tvalid & s_tready;
	assign r0       = s_tuser ? '0 : row_q;
	assign c0       = s_tuser ? '0 : col_q;
	assign r_inc    = {1'b0, r0} + (PosW+1)'(1);
	assign c_inc    = {1'b0, c0} + (PosW+1)'(1);
	assign col_wrap = c_inc >= side_n;
	assign mat_done = col_wrap && (r_inc >= side_n);

	always_comb begin
		st0.value     = s_tdata;
		st0.col       = c0;
		st0.restart   = s_tuser;
		st0.row_first = (r0 == '0);
		st0.col_first = (c0 == '0);
		st0.diag      = (r0 == c0);
		st0.last      = mat_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SizeW'(SideLimit);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
			row_q  <= '0;
			col_q  <= '0;
		end else if (accept) begin
			priority if (mat_done) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_wrap) begin
				row_q <= r_inc[PosW-1:0];
				col_q <= '0;
			end else begin
				row_q <= r0;
				col_q <= c_inc[PosW-1:0];
			end
		end
	end

	// ---------------- column bitmap memory ----------------
	logic [MAX_N-1:0] col_rdata;
	logic [MAX_N-1:0] col_next;
	logic             fwd_hit;

	mtrc_col_ram #(.DataW(MAX_N)) u_col_ram (
		.clk   (clk),
		.we    (retire),
		.waddr (st_s1.col),
		.wdata (col_next),
		.re    (accept),
		.raddr (c0),
		.rdata (col_rdata)
	);

	// Same column written back while being read: take the new word
	assign fwd_hit = retire && (st_s1.col == c0);

	// Stage 1 pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1       <= st0;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= col_next;
		end
	end

	// ---------------- stage 1: test, set, count ----------------
	logic                 v_ok;
	logic [ValueW-1:0]    v_m1;
	logic [IdxW-1:0]      idx;
	logic [MAX_N-1:0]     bit_sel;
	logic [MAX_N-1:0]     row_base, col_base;
	logic                 row_has_base, col_has_cur;
	logic [SideLimit-1:0] col_has_base, col_has_nx;
	logic                 row_hit, col_hit, row_new, col_new;
	logic [TraceW-1:0]    trace_nx;
	logic [CountW-1:0]    row_tot_nx, col_tot_nx;
	logic                 err_nx;

	assign retire   = valid_s1 && (!st_s1.last || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || retire;

	assign v_ok = (st_s1.value != '0) && ({1'b0, st_s1.value} <= (ValueW+1)'(MAX_N));
	assign v_m1 = st_s1.value - ValueW'(1);
	assign idx  = v_m1[IdxW-1:0];

	always_comb begin
		bit_sel = '0;
		if (v_ok) begin
			bit_sel[idx] = 1'b1;
		end
	end

	always_comb begin
		row_base     = st_s1.col_first ? '0 : row_seen_q;
		row_has_base = st_s1.col_first ? 1'b0 : row_has_q;
		col_base     = st_s1.row_first ? '0 : (fwd_s1 ? fwd_data_s1 : col_rdata);
		col_has_base = st_s1.restart ? '0 : col_has_q;
		col_has_cur  = col_has_base[st_s1.col];

		row_hit = |(row_base & bit_sel);
		col_hit = |(col_base & bit_sel);
		row_new = row_hit && !row_has_base;
		col_new = col_hit && !col_has_cur;

		col_next   = col_base | bit_sel;
		col_has_nx = col_has_base;
		if (col_hit) begin
			col_has_nx[st_s1.col] = 1'b1;
		end

		row_tot_nx = (st_s1.restart ? '0 : row_tot_q) + CountW'(row_new);
		col_tot_nx = (st_s1.restart ? '0 : col_tot_q) + CountW'(col_new);
		trace_nx   = (st_s1.restart ? '0 : trace_q)
			+ (st_s1.diag ? TraceW'(st_s1.value) : '0);
		err_nx     = (st_s1.restart ? 1'b0 : err_q) | !v_ok;
	end

	// Accumulated state; a finished matrix or a size write starts over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_has_q <= 1'b0;
			col_has_q <= '0;
			trace_q   <= '0;
			row_tot_q <= '0;
			col_tot_q <= '0;
			err_q     <= 1'b0;
		end else if (cfg_we || (retire && st_s1.last)) begin
			row_has_q <= 1'b0;
			col_has_q <= '0;
			trace_q   <= '0;
			row_tot_q <= '0;
			col_tot_q <= '0;
			err_q     <= 1'b0;
		end else if (retire) begin
			row_has_q <= row_has_base | row_hit;
			col_has_q <= col_has_nx;
			trace_q   <= trace_nx;
			row_tot_q <= row_tot_nx;
			col_tot_q <= col_tot_nx;
			err_q     <= err_nx;
		end
	end

	// Current-row bitmap
	always_ff @(posedge clk) begin
		if (retire) begin
			row_seen_q <= row_base | bit_sel;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire && st_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && st_s1.last) begin
			out_trace_q <= trace_nx;
			out_rows_q  <= row_tot_nx;
			out_cols_q  <= col_tot_nx;
			out_err_q   <= err_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_cols_q, out_rows_q, out_trace_q};
	assign m_tuser  = out_err_q;

endmodule

[src/mtrc_checker.sv]
`include "matrix_trace_repeat_counter_unit_macros.svh"

// Port-level checks for the matrix trace and repeat counter
module mtrc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mtrc_pkg::MDataW-1:0]   m_tdata,
	input logic                          m_tuser
);
	import mtrc_pkg::*;

	// A stalled result holds still
	`MTRC_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// Input only backs up behind an untaken result
	`MTRC_ASSERT(a_stall_cause, clk, arst_n, !s_tready |-> m_tvalid && !m_tready, "input stalled without output backpressure")

	// Repeat counts never exceed the side limit
	`MTRC_ASSERT(a_count_range, clk, arst_n, m_tvalid |-> (m_tdata[22:15] <= CountW'(SideLimit)) && (m_tdata[30:23] <= CountW'(SideLimit)), "repeat count out of range")

	// Pad bit stays zero
	`MTRC_ASSERT_ALWAYS(a_pad_zero, clk, !m_tvalid || !m_tdata[31], "tdata pad bit set")

endmodule

bind matrix_trace_repeat_counter_unit mtrc_checker u_mtrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[sim/tb_matrix_trace_repeat_counter_unit.sv]
module tb_matrix_trace_repeat_counter_unit;
	import mtrc_pkg::*;

	localparam int MaxN        = DefaultMaxN;
	localparam int RandomItems = 850;
	localparam int DrainCycles = 4;
	localparam int HoldCycles  = 300;
	localparam int CycleLimit  = 400000;

	// One matrix result as it leaves the block
	typedef struct packed {
		logic [TraceW-1:0] trace;
		logic [CountW-1:0] rows;
		logic [CountW-1:0] cols;
		logic              err;
	} totals_t;

	// Directed stimulus row: either a size write or one element
	typedef struct packed {
		bit              is_cfg;
		logic [7:0]      data;
		bit              first;
		bit              typed;
		totals_t         want;
	} stim_row_t;

	localparam totals_t NoTotals = '0;

	localparam stim_row_t DirRows [30] = '{
		// size 1: every element is a whole matrix
		'{1'b1, 8'd1,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd1,   1'b1, 1'b1, '{15'd1,   8'd0, 8'd0, 1'b0}},
		'{1'b0, 8'd128, 1'b0, 1'b1, '{15'd128, 8'd0, 8'd0, 1'b0}},
		'{1'b0, 8'd0,   1'b0, 1'b1, '{15'd0,   8'd0, 8'd0, 1'b1}},
		'{1'b0, 8'd255, 1'b1, 1'b1, '{15'd255, 8'd0, 8'd0, 1'b1}},
		// size 0 behaves as size 1
		'{1'b1, 8'd0,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd7,   1'b0, 1'b1, '{15'd7,   8'd0, 8'd0, 1'b0}},
		// 2x2 with a row and a column repeat
		'{1'b1, 8'd2,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd5,   1'b1, 1'b0, NoTotals},
		'{1'b0, 8'd5,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd5,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd3,   1'b0, 1'b0, NoTotals},
		// partial matrix dropped by a restart
		'{1'b0, 8'd9,   1'b1, 1'b0, NoTotals},
		'{1'b0, 8'd4,   1'b1, 1'b0, NoTotals},
		'{1'b0, 8'd4,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd2,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd2,   1'b0, 1'b0, NoTotals},
		// 3x3 with bad values that repeat but must not count
		'{1'b1, 8'd3,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd0,   1'b1, 1'b0, NoTotals},
		'{1'b0, 8'd0,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd0,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd200, 1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd200, 1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd200, 1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd1,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd1,   1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd1,   1'b0, 1'b0, NoTotals},
		// oversize clamps to 128; left unfinished, next write drops it
		'{1'b1, 8'd129, 1'b0, 1'b0, NoTotals},
		'{1'b0, 8'd128, 1'b1, 1'b0, NoTotals},
		'{1'b0, 8'd128, 1'b0, 1'b0, NoTotals}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SizeW-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [ValueW-1:0] s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [MDataW-1:0] m_tdata;
	logic              m_tuser;

	totals_t pending_totals [$];
	int      mismatch_count;
	bit      rx_hold_req;

	// Shadow copy of the counter state
	logic [SizeW-1:0]     size_reg;
	int                   row_pos;
	int                   col_pos;
	logic [TraceW-1:0]    trace_acc;
	logic [CountW-1:0]    row_total;
	logic [CountW-1:0]    col_total;
	logic [MaxN-1:0]      row_seen;
	bit                   row_rep;
	logic [MaxN-1:0]      col_seen [SideLimit];
	logic [SideLimit-1:0] col_rep;
	bit                   err_seen;

	matrix_trace_repeat_counter_unit #(
		.MAX_N(MaxN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Effective side length: 0 acts as 1, anything above the limit clamps
	function automatic int side_of(logic [SizeW-1:0] s);
		if (s == 0)
			return 1;
		if (s > SideLimit)
			return SideLimit;
		return int'(s);
	endfunction

	// Idle length: mostly short, a few long
	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic clear_matrix();
		row_pos   = 0;
		col_pos   = 0;
		trace_acc = '0;
		row_total = '0;
		col_total = '0;
		row_rep   = 1'b0;
		col_rep   = '0;
		err_seen  = 1'b0;
	endtask

	// Trace and repeat totals after one more element
	task automatic tally_element(input logic [7:0] v, input bit first,
			output bit done, output totals_t res);
		int n;
		int r;
		int c;
		int idx;
		n    = side_of(size_reg);
		done = 1'b0;
		res  = '0;
		if (first)
			clear_matrix();
		r = row_pos;
		c = col_pos;
		if (c == 0) begin
			row_seen = '0;
			row_rep  = 1'b0;
		end
		if (r == 0)
			col_seen[c] = '0;
		if (v == 0 || v > MaxN) begin
			err_seen = 1'b1;
		end else begin
			idx = int'(v) - 1;
			if (row_seen[idx] && !row_rep) begin
				row_rep   = 1'b1;
				row_total = row_total + 1'b1;
			end
			row_seen[idx] = 1'b1;
			if (col_seen[c][idx] && !col_rep[c]) begin
				col_rep[c] = 1'b1;
				col_total  = col_total + 1'b1;
			end
			col_seen[c][idx] = 1'b1;
		end
		if (r == c)
			trace_acc = trace_acc + TraceW'(v);
		c++;
		if (c >= n) begin
			c = 0;
			r++;
		end
		col_pos = c;
		row_pos = r;
		if (r >= n) begin
			res.trace = trace_acc;
			res.rows  = row_total;
			res.cols  = col_total;
			res.err   = err_seen;
			done      = 1'b1;
			clear_matrix();
		end
	endtask

	task automatic wait_drained();
		while (pending_totals.size() != 0)
			@(posedge clk);
	endtask

	// Size write with the pipeline empty
	task automatic write_size(input logic [SizeW-1:0] v);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
		size_reg = v;
		clear_matrix();
	endtask

	// Offer one element, wait for the transaction, then idle for gap cycles
	task automatic send_element(input logic [7:0] v, input bit first, input bit typed,
			input totals_t want, input int gap);
		bit      done;
		totals_t res;
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= first;
		do
			@(posedge clk);
		while (!s_tready);
		tally_element(v, first, done, res);
		if (done)
			pending_totals = {pending_totals, (typed ? want : res)};
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// Watchdog
	initial begin
		int cycle_count;
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CycleLimit) begin
				$display("%0t timeout with %0d results outstanding", $time,
					pending_totals.size());
				$display("matrix_trace_repeat_counter_unit regression: fail");
				$finish;
			end
		end
	end

	// Result side: check each transaction, stall at random
	initial begin
		int      gap_left;
		int      mode_left;
		int      hold_left;
		bit      quiet;
		totals_t got;
		totals_t want;
		gap_left  = 0;
		mode_left = 0;
		hold_left = 0;
		quiet     = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.trace = m_tdata[TraceW-1:0];
				got.rows  = m_tdata[TraceW +: CountW];
				got.cols  = m_tdata[TraceW+CountW +: CountW];
				got.err   = m_tuser;
				if (pending_totals.size() == 0) begin
					$display("%0t unexpected result: trace %0d rows %0d cols %0d err %0d",
						$time, got.trace, got.rows, got.cols, got.err);
					mismatch_count++;
				end else begin
					want = pending_totals.pop_front();
					check_field("trace_sum", int'(want.trace), int'(got.trace));
					check_field("rows_with_repeat", int'(want.rows), int'(got.rows));
					check_field("cols_with_repeat", int'(want.cols), int'(got.cols));
					check_field("value_error", int'(want.err), int'(got.err));
				end
			end
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = HoldCycles;
			end
			// alternate stretches with and without stalls
			if (mode_left == 0) begin
				mode_left = $urandom_range(50, 300);
				quiet     = ($urandom_range(0, 3) == 0);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					gap_left = pick_gap(1'b0);
			end
		end
	end

	// Stimulus
	initial begin
		int         phase;
		int         rand_items;
		int         pick;
		int         n;
		int         len;
		int         mats;
		int         style;
		int         r;
		int         c;
		int         sel;
		bit         quiet;
		bit         first;
		bit         restart_next;
		logic [7:0] size_val;
		logic [7:0] val;

		mismatch_count = 0;
		rx_hold_req    = 1'b0;
		size_reg       = SizeW'(SideLimit);
		row_seen       = '0;
		foreach (col_seen[i])
			col_seen[i] = '0;
		clear_matrix();

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (DirRows[i]) begin
			if (DirRows[i].is_cfg)
				write_size(DirRows[i].data);
			else
				send_element(DirRows[i].data, DirRows[i].first, DirRows[i].typed,
					DirRows[i].want, pick_gap(1'b0));
		end

		// Random phases, each under its own matrix size
		phase      = 0;
		rand_items = 0;
		while (rand_items < RandomItems) begin
			pick = $urandom_range(0, 99);
			if (phase == 0) begin
				size_val = 8'd1;
			end else if (pick < 7) begin
				sel = $urandom_range(0, 3);
				size_val = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd128 :
					(sel == 2) ? 8'd129 : 8'd255;
			end else if (pick < 75) begin
				size_val = 8'($urandom_range(1, 5));
			end else begin
				size_val = 8'($urandom_range(6, 12));
			end
			write_size(size_val);
			n            = side_of(size_val);
			quiet        = (phase == 0) || ($urandom_range(0, 4) == 0);
			restart_next = 1'b0;
			// first phase: long result-side stall against a steady input stream
			if (phase == 0)
				rx_hold_req = 1'b1;

			if (n == SideLimit) begin
				// full-size matrix: only a partial one, dropped by the next write
				len = $urandom_range(40, 200);
				for (int k = 0; k < len; k++) begin
					val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(1, MaxN));
					first = (k == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
					send_element(val, first, 1'b0, NoTotals, pick_gap(quiet));
					rand_items++;
				end
			end else begin
				mats = (phase == 0) ? 40 : $urandom_range(1, 4);
				for (int m = 0; m < mats; m++) begin
					style = $urandom_range(0, 9);
					len   = n * n;
					// broken matrix: cut short, next one restarts
					if (style == 9 && len > 1)
						len = $urandom_range(1, len - 1);
					for (int k = 0; k < len; k++) begin
						r = k / n;
						c = k % n;
						case (style)
							0, 1: val = 8'(((r + c) % n) + 1);
							7: val = 8'($urandom_range(0, 255));
							8: begin
								sel = $urandom_range(0, 9);
								case (sel)
									0: val = 8'd0;
									1: val = 8'(MaxN);
									2: val = 8'd255;
									3: val = 8'($urandom_range(MaxN + 1, 254));
									default: val = 8'($urandom_range(1, n));
								endcase
							end
							default: val = 8'($urandom_range(1, n));
						endcase
						first = (k == 0) ? (restart_next | 1'($urandom_range(0, 1))) : 1'b0;
						send_element(val, first, 1'b0, NoTotals, pick_gap(quiet));
						rand_items++;
					end
					restart_next = (style == 9 && n * n > 1);
					// sender pause until every pending result is out
					if (phase == 0 && m == mats - 1 || $urandom_range(0, 7) == 0) begin
						s_tvalid <= 1'b0;
						@(posedge clk);
						wait_drained();
					end
				end
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (DrainCycles * 2) @(posedge clk);
		if (mismatch_count == 0)
			$display("matrix_trace_repeat_counter_unit regression: pass");
		else
			$display("matrix_trace_repeat_counter_unit regression: fail");
		$finish;
	end

endmodule

[matrix_trace_repeat_counter_unit.f]
+incdir+src
src/mtrc_pkg.sv
src/mtrc_col_ram.sv
src/matrix_trace_repeat_counter_unit.sv
src/mtrc_checker.sv
sim/tb_matrix_trace_repeat_counter_unit.sv
